@@ design/mmc3_pkg.sv @@
package mmc3_pkg;

   // Kind of each request word, carried on req_tuser
   typedef enum logic [2:0] {
      ACT_WRITE = 3'd0,
      ACT_READ  = 3'd1,
      ACT_TICK  = 3'd2,
      ACT_PRG   = 3'd3,
      ACT_CHR   = 3'd4
   } action_type;

   // Configuration registers, selected by paddr[2]
   typedef enum logic {
      REG_PRG_BANK_COUNT = 1'b0,
      REG_CHR_TWICE_PRG  = 1'b1
   } csr_index_type;

   // 0x8000-0x9FFF decode on address bits 1:0
   typedef enum logic [1:0] {
      MAP_COMMAND = 2'd0,
      MAP_DATA    = 2'd1,
      MAP_NONE    = 2'd2,
      MAP_EXT     = 2'd3
   } map_port_type;

   // 0xA000-0xFFFF decode on {address[15:13], address[0]}
   typedef enum logic [3:0] {
      IRQ_MIRROR  = 4'b1010,
      IRQ_UNUSED  = 4'b1011,
      IRQ_COUNTER = 4'b1100,
      IRQ_LATCH   = 4'b1101,
      IRQ_DISABLE = 4'b1110,
      IRQ_ENABLE  = 4'b1111
   } irq_port_type;

   // Extended mode codes (low six bits of the mode byte)
   localparam logic [5:0] EXT_LOCK_A   = 6'h20;
   localparam logic [5:0] EXT_LOCK_B   = 6'h29;
   localparam logic [5:0] EXT_LOCK_C   = 6'h2B;
   localparam logic [5:0] EXT_LOCK_D   = 6'h3C;
   localparam logic [5:0] EXT_LOCK_E   = 6'h3F;
   localparam logic [5:0] EXT_OPEN_0   = 6'h26;
   localparam logic [5:0] EXT_LOCK_NZ  = 6'h2C;
   localparam logic [5:0] EXT_OPEN_1   = 6'h28;
   localparam logic [5:0] EXT_OPEN_2   = 6'h2A;
   localparam logic [5:0] EXT_HOLD     = 6'h2F;

   localparam logic [15:0] OUTER_MASK       = 16'h5180;
   localparam logic [3:0]  PROT_PAGE        = 4'h5;
   localparam logic [8:0]  LAST_VISIBLE     = 9'd239;
   localparam logic [6:0]  PRG_COUNT_RESET  = 7'd64;
   localparam logic [7:0]  OUTER_RESET      = 8'h80;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_ADDR_W = 3;

   localparam logic [7:0] BANK_RESET [8] = '{8'd0, 8'd2, 8'd4, 8'd5, 8'd6, 8'd7, 8'd0, 8'd1};
   localparam logic [8:0] CHR_RESET [8] = '{9'h100, 9'h101, 9'h102, 9'h103,
                                            9'h104, 9'h105, 9'h106, 9'h107};

   function automatic logic [7:0] prot_lookup(input logic [1:0] sel);
      logic [7:0] res;
      case (sel)
         2'd0:    res = 8'h83;
         2'd1:    res = 8'h83;
         2'd2:    res = 8'h42;
         default: res = 8'h00;
      endcase
      return res;
   endfunction

   function automatic logic [5:0] bit_reverse6(input logic [5:0] d);
      return {d[0], d[1], d[2], d[3], d[4], d[5]};
   endfunction

   // Bank register that feeds a 1K slot offset (0,1 from R0; 2,3 from R1; 4..7 from R2..R5)
   function automatic logic [2:0] chr_source_reg(input logic [2:0] off);
      logic [2:0] res;
      case (off)
         3'd0, 3'd1: res = 3'd0;
         3'd2, 3'd3: res = 3'd1;
         default:    res = off - 3'd2;
      endcase
      return res;
   endfunction

   function automatic logic [7:0] chr_source_val(input logic [7:0] regs [8],
                                                 input logic [2:0] off);
      logic [7:0] res;
      case (off)
         3'd0:    res = regs[0] & 8'hFE;
         3'd1:    res = regs[0] | 8'h01;
         3'd2:    res = regs[1] & 8'hFE;
         3'd3:    res = regs[1] | 8'h01;
         default: res = regs[chr_source_reg(off)];
      endcase
      return res;
   endfunction

endpackage

@@ design/mmc3_clone_bank_mapper_with_protection.sv @@
// MMC3-clone bank mapper with protection latch and extended PRG mode. Each request word is
// one of a CPU write, a CPU read, a scanline tick, a PRG bank query or a CHR bank query
// (req_tuser). Every word yields exactly one response word, registered in the cycle after
// acceptance; the block takes a word in every cycle while the response register is empty
// or being drained, so throughput is one word per clock. State updates and lookups are all
// done in a single combinational pass from the register file to the response register.
// CHR banks are kept per 1K slot, rebuilt on CHR bank or outer writes and on a change of
// command bit 7; a change of chr_twice_prg reaches the CHR slots only at their next rebuild,
// while prg_bank_count acts at once. Bank numbers are raw (not reduced modulo ROM size).
module mmc3_clone_bank_mapper_with_protection
   import mmc3_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_tvalid,
   output logic                    req_tready,
   // address[15:0], write_data[23:16], scanline[32:24], display_on[33], zero[39:34]
   input  logic [REQ_DATA_W-1:0]   req_tdata,
   // action[2:0]
   input  logic [2:0]              req_tuser,

   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // read_data[7:0], read_hit[8], bank[17:9], mirror_horizontal[18], irq_line[19], zero[23:20]
   output logic [RSP_DATA_W-1:0]   rsp_tdata,

   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CSR_ADDR_W-1:0]   paddr,
   input  logic [31:0]             pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   logic          accept;
   action_type    act;
   logic [15:0]   addr;
   logic [7:0]    wd;
   logic [8:0]    line;
   logic          disp;

   logic [6:0]    prg_count_ff;
   logic          twice_ff;

   logic [7:0]    cmd_ff, cmd_in;
   logic [7:0]    regs_ff [8];
   logic [7:0]    regs_in [8];
   logic [7:0]    prot_ff, prot_in;
   logic [7:0]    outer_ff, outer_in;
   logic [5:0]    mode_ff, mode_in;
   logic [5:0]    rev_ff, rev_in;
   logic          elock_ff, elock_in;
   logic [5:0]    ebank_ff [3];
   logic [5:0]    ebank_in [3];
   logic [8:0]    chr_ff [8];
   logic [8:0]    chr_in [8];
   logic          mirror_ff, mirror_in;
   logic [7:0]    cnt_ff, cnt_in;
   logic [7:0]    latch_ff, latch_in;
   logic          irq_en_ff, irq_en_in;
   logic          rlock_ff, rlock_in;
   logic          pend_ff, pend_in;

   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   assign act  = action_type'(req_tuser);
   assign addr = req_tdata[15:0];
   assign wd   = req_tdata[23:16];
   assign line = req_tdata[32:24];
   assign disp = req_tdata[33];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Configuration port
   assign pready = 1'b1;

   always_comb begin
      case (csr_index_type'(paddr[2]))
         REG_PRG_BANK_COUNT: prdata = {25'd0, prg_count_ff};
         REG_CHR_TWICE_PRG:  prdata = {31'd0, twice_ff};
         default:            prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_count_ff <= PRG_COUNT_RESET;
         twice_ff     <= 1'b1;
      end else if (psel && penable && pwrite && pready) begin
         case (csr_index_type'(paddr[2]))
            REG_PRG_BANK_COUNT: prg_count_ff <= pwdata[6:0];
            REG_CHR_TWICE_PRG:  twice_ff     <= pwdata[0];
            default:            ;
         endcase
      end
   end

   // Next state and response
   always_comb begin
      logic          ext_run;
      logic [5:0]    ext_mode;
      logic [5:0]    ext_rev;
      logic          refresh_all;
      logic          refresh_one;
      logic          layout7;
      logic          test7;
      logic [2:0]    data_reg;
      logic [2:0]    off;
      logic          hi8;
      logic [7:0]    c;
      logic [4:0]    last1;
      logic [4:0]    last2;
      logic [4:0]    r6;
      logic [5:0]    hi;
      logic          ext_on;
      logic          swap;
      logic [5:0]    prg;
      logic [7:0]    rdata;
      logic          hit;
      logic [8:0]    bank;

      cmd_in    = cmd_ff;
      regs_in   = regs_ff;
      prot_in   = prot_ff;
      outer_in  = outer_ff;
      mode_in   = mode_ff;
      rev_in    = rev_ff;
      elock_in  = elock_ff;
      ebank_in  = ebank_ff;
      chr_in    = chr_ff;
      mirror_in = mirror_ff;
      cnt_in    = cnt_ff;
      latch_in  = latch_ff;
      irq_en_in = irq_en_ff;
      rlock_in  = rlock_ff;
      pend_in   = pend_ff;

      ext_run     = 1'b0;
      ext_mode    = mode_ff;
      ext_rev     = rev_ff;
      refresh_all = 1'b0;
      refresh_one = 1'b0;
      layout7     = cmd_ff[7];
      test7       = cmd_ff[7];
      data_reg    = cmd_ff[2:0];
      c           = cnt_ff;
      rdata       = 8'd0;
      hit         = 1'b0;
      bank        = 9'd0;

      last2  = prg_count_ff[4:0] - 5'd2;
      last1  = prg_count_ff[4:0] - 5'd1;
      r6     = regs_ff[6][4:0];
      hi     = {outer_ff[7], 5'd0};
      ext_on = (mode_ff != 6'd0);
      swap   = cmd_ff[6];
      prg    = 6'd0;

      if (accept) begin
         case (act)
            ACT_WRITE: begin
               if (addr[15:12] == PROT_PAGE) begin
                  prot_in = prot_lookup(wd[1:0]);
                  if ((addr & OUTER_MASK) == OUTER_MASK) begin
                     outer_in    = wd;
                     refresh_all = 1'b1;
                  end
               end else if (addr[15:13] == 3'b100) begin
                  case (map_port_type'(addr[1:0]))
                     MAP_COMMAND: begin
                        // new layout, half test still from the old command byte
                        if (wd[7] != cmd_ff[7]) begin
                           refresh_all = 1'b1;
                           layout7     = wd[7];
                        end
                        cmd_in = wd;
                     end
                     MAP_DATA: begin
                        rev_in            = bit_reverse6(wd[5:0]);
                        ext_rev           = rev_in;
                        ext_run           = !elock_ff;
                        regs_in[data_reg] = wd;
                        refresh_one       = 1'b1;
                     end
                     MAP_EXT: begin
                        mode_in  = wd[5:0];
                        ext_mode = wd[5:0];
                        ext_run  = 1'b1;
                        if (wd[7] != cmd_ff[7]) begin
                           refresh_all = 1'b1;
                           layout7     = wd[7];
                        end
                        cmd_in = wd;
                     end
                     default: ;
                  endcase
               end else if (addr[15:13] >= 3'b101) begin
                  case (irq_port_type'({addr[15:13], addr[0]}))
                     IRQ_MIRROR:  mirror_in = wd[0];
                     IRQ_COUNTER: begin
                        rlock_in = 1'b0;
                        cnt_in   = wd;
                     end
                     IRQ_LATCH: begin
                        rlock_in = 1'b0;
                        latch_in = wd;
                     end
                     IRQ_DISABLE: begin
                        rlock_in  = 1'b0;
                        irq_en_in = 1'b0;
                        pend_in   = 1'b0;
                     end
                     IRQ_ENABLE: begin
                        rlock_in  = 1'b0;
                        irq_en_in = 1'b1;
                     end
                     default: ;
                  endcase
               end
            end
            ACT_READ: begin
               if (addr[15:12] == PROT_PAGE) begin
                  rdata = prot_ff;
                  hit   = 1'b1;
               end
            end
            ACT_TICK: begin
               if (line <= LAST_VISIBLE && disp && irq_en_ff && !rlock_ff) begin
                  if (line == 9'd0 && c != 8'd0) begin
                     c = c - 8'd1;
                  end
                  if (c == 8'd0) begin
                     rlock_in = 1'b1;
                     c        = latch_ff;
                     pend_in  = 1'b1;
                  end
                  cnt_in = c - 8'd1;
               end
            end
            ACT_PRG: begin
               if (addr[15]) begin
                  case (addr[14:13])
                     2'd0:    prg = {1'b0, swap ? last2 : r6} | hi;
                     2'd1:    prg = ext_on ? (ebank_ff[2] | hi)
                                           : ({1'b0, regs_ff[7][4:0]} | hi);
                     2'd2:    prg = ext_on ? (ebank_ff[1] | hi)
                                           : ({1'b0, swap ? r6 : last2} | hi);
                     default: prg = ext_on ? (ebank_ff[0] | hi) : ({1'b0, last1} | hi);
                  endcase
               end
               bank = {3'd0, prg};
            end
            ACT_CHR: begin
               if (addr[15:13] == 3'd0) begin
                  bank = chr_ff[addr[12:10]];
               end
            end
            default: ;
         endcase
      end

      // Extended mode update
      if (ext_run) begin
         case (ext_mode)
            EXT_LOCK_A, EXT_LOCK_B, EXT_LOCK_C, EXT_LOCK_D, EXT_LOCK_E: begin
               elock_in    = 1'b1;
               ebank_in[0] = ext_rev;
            end
            EXT_OPEN_0: begin
               elock_in    = 1'b0;
               ebank_in[0] = ext_rev;
            end
            EXT_LOCK_NZ: begin
               elock_in = 1'b1;
               if (ext_rev != 6'd0) begin
                  ebank_in[0] = ext_rev;
               end
            end
            EXT_OPEN_1: begin
               elock_in    = 1'b0;
               ebank_in[1] = ext_rev;
            end
            EXT_OPEN_2: begin
               elock_in    = 1'b0;
               ebank_in[2] = ext_rev;
            end
            EXT_HOLD: ;
            default: mode_in = 6'd0;
         endcase
      end

      // Rebuild CHR slots: each slot maps back to its offset in the current layout
      for (int s = 0; s < 8; s++) begin
         off = 3'(s) ^ {layout7, 2'b00};
         hi8 = twice_ff ? outer_in[7] : (3'(s) >> 2 == {2'b00, test7});
         if (refresh_all || (refresh_one && data_reg <= 3'd5 &&
                             chr_source_reg(off) == data_reg)) begin
            chr_in[3'(s)] = {hi8, chr_source_val(regs_in, off)};
         end
      end

      rsp_data_in = {4'd0, pend_in, mirror_in, bank, hit, rdata};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff    <= 8'd0;
         regs_ff   <= BANK_RESET;
         prot_ff   <= 8'd0;
         outer_ff  <= OUTER_RESET;
         mode_ff   <= 6'd0;
         rev_ff    <= 6'd0;
         elock_ff  <= 1'b0;
         ebank_ff  <= '{6'd0, 6'd0, 6'd0};
         chr_ff    <= CHR_RESET;
         mirror_ff <= 1'b0;
         cnt_ff    <= 8'd0;
         latch_ff  <= 8'd0;
         irq_en_ff <= 1'b0;
         rlock_ff  <= 1'b0;
         pend_ff   <= 1'b0;
      end else if (accept) begin
         cmd_ff    <= cmd_in;
         regs_ff   <= regs_in;
         prot_ff   <= prot_in;
         outer_ff  <= outer_in;
         mode_ff   <= mode_in;
         rev_ff    <= rev_in;
         elock_ff  <= elock_in;
         ebank_ff  <= ebank_in;
         chr_ff    <= chr_in;
         mirror_ff <= mirror_in;
         cnt_ff    <= cnt_in;
         latch_ff  <= latch_in;
         irq_en_ff <= irq_en_in;
         rlock_ff  <= rlock_in;
         pend_ff   <= pend_in;
      end
   end

   // Response register: load on accept, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

@@ design/mmc3_chk.sv @@
module mmc3_chk
   import mmc3_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tready,
   input  logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic [RSP_DATA_W-1:0]   rsp_tdata
);

   // A stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed while stalled");

   // Empty output side never back-pressures the request side
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty response register");

   // Every accepted word shows up as a response in the next cycle
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted word produced no response");

   // Read data only with a hit
   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[8] |-> rsp_tdata[7:0] == 8'd0)
      else $error("read data without a hit");

   // A read hit carries no bank number
   a_hit_no_bank: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8] |-> rsp_tdata[17:9] == 9'd0)
      else $error("bank number on a read hit");

endmodule

bind mmc3_clone_bank_mapper_with_protection mmc3_chk u_mmc3_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ tb/mmc3_clone_bank_mapper_with_protection_tb.sv @@
module mmc3_clone_bank_mapper_with_protection_tb;
   import mmc3_pkg::*;

   localparam logic [2:0] ACT_SPARE_LO = 3'd5;
   localparam logic [2:0] ACT_SPARE_HI = 3'd7;
   localparam logic [5:0] EXT_CODES [10] = '{EXT_LOCK_A, EXT_LOCK_B, EXT_LOCK_C, EXT_LOCK_D,
                                             EXT_LOCK_E, EXT_OPEN_0, EXT_LOCK_NZ, EXT_OPEN_1,
                                             EXT_OPEN_2, EXT_HOLD};

   typedef struct packed {
      logic [7:0] read_data;
      logic       read_hit;
      logic [8:0] bank;
      logic       mirror_h;
      logic       irq;
   } mapper_reply_type;

   class mapper_scoreboard;
      logic [6:0]    bank_count;
      logic          chr_double;
      logic [7:0]    cmd_reg;
      logic [7:0]    bank_reg [8];
      logic [7:0]    prot_val;
      logic [7:0]    outer_val;
      logic [7:0]    ext_mode;
      logic [5:0]    rev_val;
      logic          ext_locked;
      logic [7:0]    ext_bank [3];
      logic [8:0]    chr_slot [8];
      logic          mirror_h;
      logic [7:0]    irq_count;
      logic [7:0]    irq_reload;
      logic          irq_on;
      logic          irq_hold;
      logic          irq_flag;
      mapper_reply_type replies [$];
      int unsigned   mismatches;

      function new();
         mismatches = 0;
         bank_count = PRG_COUNT_RESET;
         chr_double = 1'b1;
         cmd_reg = '0;
         for (int k = 0; k < 8; k++) bank_reg[k] = BANK_RESET[k];
         prot_val = '0;
         outer_val = OUTER_RESET;
         ext_mode = '0;
         rev_val = '0;
         ext_locked = 1'b0;
         for (int k = 0; k < 3; k++) ext_bank[k] = '0;
         mirror_h = 1'b0;
         irq_count = '0;
         irq_reload = '0;
         irq_on = 1'b0;
         irq_hold = 1'b0;
         irq_flag = 1'b0;
         rebuild_chr(cmd_reg);
      endfunction

      function void set_config(csr_index_type idx, logic [31:0] v);
         if (idx == REG_PRG_BANK_COUNT) bank_count = v[6:0];
         else chr_double = v[0];
      endfunction

      // Bit 8 follows the outer byte, or marks the half that holds the 2K banks
      function void put_chr_slot(logic [12:0] ppu, logic [7:0] v);
         logic [8:0] b;
         b = {1'b0, v};
         if (chr_double) b[8] = outer_val[7];
         else if (ppu[12] == cmd_reg[7]) b[8] = 1'b1;
         chr_slot[ppu[12:10]] = b;
      endfunction

      // Layout follows cmd, the half test keeps the current command byte
      function void rebuild_chr(logic [7:0] cmd);
         logic [12:0] base;
         base = {cmd[7], 12'h000};
         put_chr_slot(base ^ 13'h0000, bank_reg[0] & 8'hFE);
         put_chr_slot(base ^ 13'h0400, bank_reg[0] | 8'h01);
         put_chr_slot(base ^ 13'h0800, bank_reg[1] & 8'hFE);
         put_chr_slot(base ^ 13'h0C00, bank_reg[1] | 8'h01);
         for (int k = 2; k < 6; k++)
            put_chr_slot(base ^ (13'h1000 + 13'(k - 2) * 13'h0400), bank_reg[k]);
      endfunction

      function void write_command(logic [7:0] v);
         if ((v[7] ^ cmd_reg[7]) != 1'b0) rebuild_chr(v);
         cmd_reg = v;
      endfunction

      function void write_bank_data(logic [7:0] v);
         logic [2:0]  r;
         logic [12:0] base;
         r = cmd_reg[2:0];
         base = {cmd_reg[7], 12'h000};
         bank_reg[r] = v;
         if (r == 3'd0) begin
            put_chr_slot(base, v & 8'hFE);
            put_chr_slot(base ^ 13'h0400, v | 8'h01);
         end else if (r == 3'd1) begin
            put_chr_slot(base ^ 13'h0800, v & 8'hFE);
            put_chr_slot(base ^ 13'h0C00, v | 8'h01);
         end else if (r <= 3'd5) begin
            put_chr_slot(base ^ (13'h1000 + {r - 3'd2, 10'h000}), v);
         end
      endfunction

      function void apply_ext_mode();
         case (ext_mode[5:0])
            EXT_LOCK_A, EXT_LOCK_B, EXT_LOCK_C, EXT_LOCK_D, EXT_LOCK_E: begin
               ext_locked = 1'b1;
               ext_bank[0] = {2'b00, rev_val};
            end
            EXT_OPEN_0: begin
               ext_locked = 1'b0;
               ext_bank[0] = {2'b00, rev_val};
            end
            EXT_LOCK_NZ: begin
               ext_locked = 1'b1;
               if (rev_val != 6'd0) ext_bank[0] = {2'b00, rev_val};
            end
            EXT_OPEN_1: begin
               ext_locked = 1'b0;
               ext_bank[1] = {2'b00, rev_val};
            end
            EXT_OPEN_2: begin
               ext_locked = 1'b0;
               ext_bank[2] = {2'b00, rev_val};
            end
            EXT_HOLD: ;
            default: ext_mode = '0;
         endcase
      endfunction

      function logic [8:0] prg_lookup(logic [15:0] addr);
         logic [4:0] last2;
         logic [4:0] last1;
         logic [4:0] r6;
         logic [8:0] hi;
         logic       swap;
         logic       ext;
         logic [8:0] res;
         hi = {3'b000, outer_val[7], 5'b00000};
         last2 = bank_count[4:0] - 5'd2;
         last1 = bank_count[4:0] - 5'd1;
         r6 = bank_reg[6][4:0];
         swap = cmd_reg[6];
         ext = ext_mode[5:0] != 6'd0;
         if (!addr[15]) return 9'd0;
         case (addr[14:13])
            2'd0: res = {4'b0000, swap ? last2 : r6} | hi;
            2'd1: res = ext ? ({1'b0, ext_bank[2]} | hi) : ({4'b0000, bank_reg[7][4:0]} | hi);
            2'd2: res = ext ? ({1'b0, ext_bank[1]} | hi) : ({4'b0000, swap ? r6 : last2} | hi);
            default: res = ext ? ({1'b0, ext_bank[0]} | hi) : ({4'b0000, last1} | hi);
         endcase
         return res;
      endfunction

      function void cpu_store(logic [15:0] addr, logic [7:0] d);
         if (addr[15:12] == PROT_PAGE) begin
            case (d[1:0])
               2'd2:    prot_val = 8'h42;
               2'd3:    prot_val = 8'h00;
               default: prot_val = 8'h83;
            endcase
            if ((addr & OUTER_MASK) == OUTER_MASK) begin
               outer_val = d;
               rebuild_chr(cmd_reg);
            end
         end else if (addr[15:13] == 3'b100) begin
            case (map_port_type'(addr[1:0]))
               MAP_COMMAND: write_command(d);
               MAP_DATA: begin
                  rev_val = {d[0], d[1], d[2], d[3], d[4], d[5]};
                  if (!ext_locked) apply_ext_mode();
                  write_bank_data(d);
               end
               MAP_EXT: begin
                  ext_mode = d;
                  apply_ext_mode();
                  write_command(d);
               end
               default: ;
            endcase
         end else if (addr >= 16'hA000) begin
            case (irq_port_type'({addr[15:13], addr[0]}))
               IRQ_MIRROR: mirror_h = d[0];
               IRQ_COUNTER: begin
                  irq_hold = 1'b0;
                  irq_count = d;
               end
               IRQ_LATCH: begin
                  irq_hold = 1'b0;
                  irq_reload = d;
               end
               IRQ_DISABLE: begin
                  irq_hold = 1'b0;
                  irq_on = 1'b0;
                  irq_flag = 1'b0;
               end
               IRQ_ENABLE: begin
                  irq_hold = 1'b0;
                  irq_on = 1'b1;
               end
               default: ;
            endcase
         end
      endfunction

      function void scanline_tick(logic [8:0] line, logic disp);
         if (line > LAST_VISIBLE || !disp || !irq_on || irq_hold) return;
         if (line == 9'd0 && irq_count != 8'd0) irq_count = irq_count - 8'd1;
         // reload fires and locks out further ticks until an IRQ register write
         if (irq_count == 8'd0) begin
            irq_hold = 1'b1;
            irq_count = irq_reload;
            irq_flag = 1'b1;
         end
         irq_count = irq_count - 8'd1;
      endfunction

      function void note_request(logic [2:0] act, logic [15:0] addr, logic [7:0] d,
                                 logic [8:0] line, logic disp);
         mapper_reply_type r;
         r = '0;
         case (act)
            ACT_WRITE: cpu_store(addr, d);
            ACT_READ: begin
               if (addr[15:12] == PROT_PAGE) begin
                  r.read_data = prot_val;
                  r.read_hit = 1'b1;
               end
            end
            ACT_TICK: scanline_tick(line, disp);
            ACT_PRG:  r.bank = prg_lookup(addr);
            ACT_CHR: begin
               if (addr < 16'h2000) r.bank = chr_slot[addr[12:10]];
            end
            default: ;
         endcase
         r.mirror_h = mirror_h;
         r.irq = irq_flag;
         replies.push_back(r);
      endfunction

      function void flag(string what, logic [31:0] want, logic [31:0] got);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch %s: expected %0h, got %0h at %0t", what, want, got, $time);
      endfunction

      function void check_response(logic [RSP_DATA_W-1:0] word);
         mapper_reply_type want;
         if (replies.size() == 0) begin
            flag("unexpected word", 32'd0, 32'(word));
            return;
         end
         want = replies.pop_front();
         if (word[7:0] != want.read_data)
            flag("read_data", 32'(want.read_data), 32'(word[7:0]));
         if (word[8] != want.read_hit)
            flag("read_hit", 32'(want.read_hit), 32'(word[8]));
         if (word[17:9] != want.bank)
            flag("bank", 32'(want.bank), 32'(word[17:9]));
         if (word[18] != want.mirror_h)
            flag("mirror_horizontal", 32'(want.mirror_h), 32'(word[18]));
         if (word[19] != want.irq)
            flag("irq_line", 32'(want.irq), 32'(word[19]));
      endfunction

      function int pending();
         return replies.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [2:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0]           pwdata = '0;
   logic [31:0]           prdata;
   logic                  pready;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_req = 0;
   mapper_scoreboard sb;

   mmc3_clone_bank_mapper_with_protection dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
   end

   // Receiver: random stalls, plus a long hold-off when asked
   initial begin
      forever begin
         @(negedge clock);
         if (hold_req != 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_req) @(negedge clock);
            hold_req = 0;
         end
         rsp_tready <= (rsp_stall_pct == 0) || ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   initial begin
      #3000000;
      $display("mmc3_clone_bank_mapper_with_protection verification failed");
      $finish;
   end

   // Call at a falling edge; returns at a falling edge
   task automatic send_word(input logic [2:0] act, input logic [15:0] addr,
                            input logic [7:0] d, input logic [8:0] line, input logic disp);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {6'b000000, disp, line, d, addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(act, addr, d, line, disp);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [31:0] v);
      logic [31:0] want;
      want = (idx == REG_PRG_BANK_COUNT) ? {25'd0, v[6:0]} : {31'd0, v[0]};
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {idx, 2'b00};
      pwdata <= v;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      sb.set_config(idx, v);
      @(negedge clock);
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata != want) sb.flag("register readback", want, prdata);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_random_word();
      int          kind;
      logic [2:0]  act;
      logic [15:0] a;
      logic [7:0]  d;
      logic [8:0]  line;
      logic        disp;
      kind = $urandom_range(99);
      act = ACT_WRITE;
      a = 16'($urandom);
      d = 8'($urandom);
      line = 9'($urandom_range(261));
      disp = $urandom_range(99) < 85;
      if (kind < 12) begin
         a = {PROT_PAGE, a[11:0]};
         if ($urandom_range(1) == 0) a = a | OUTER_MASK;
      end else if (kind < 36) begin
         a = {3'b100, a[12:0]};
         // steer mode writes to the codes that take effect
         if (a[1:0] == 2'(MAP_EXT) && $urandom_range(2) != 0)
            d = {d[7:6], EXT_CODES[$urandom_range(9)]};
      end else if (kind < 50) begin
         a = {3'($urandom_range(7, 5)), a[12:0]};
         if (a[15:14] == 2'b11 && $urandom_range(1) == 0) d = 8'($urandom_range(6));
      end else if (kind < 66) begin
         act = ACT_TICK;
         if ($urandom_range(4) == 0) line = 9'd0;
      end else if (kind < 78) begin
         act = ACT_PRG;
         if ($urandom_range(9) != 0) a[15] = 1'b1;
      end else if (kind < 90) begin
         act = ACT_CHR;
         if ($urandom_range(9) != 0) a[15:13] = 3'b000;
      end else if (kind < 96) begin
         act = ACT_READ;
         if ($urandom_range(3) != 0) a[15:12] = PROT_PAGE;
      end else if (kind < 98) begin
         act = ACT_WRITE;
      end else begin
         act = 3'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
      end
      send_word(act, a, d, line, disp);
   endtask

   logic [6:0] cfg_count [6] = '{7'd64, 7'd2, 7'd127, 7'd0, 7'd64, 7'd1};
   logic       cfg_double [6] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
   int         idle_send [6] = '{0, 55, 0, 28, 0, 28};
   int         idle_recv [6] = '{0, 0, 55, 28, 0, 28};

   initial begin
      sb = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_word(ACT_PRG, 16'h7FFF, 8'h00, 9'd0, 1'b0);
      send_word(ACT_PRG, 16'h8000, 8'h00, 9'd0, 1'b0);
      send_word(ACT_PRG, 16'hFFFF, 8'h00, 9'd0, 1'b0);
      send_word(ACT_CHR, 16'h0000, 8'h00, 9'd0, 1'b0);
      send_word(ACT_CHR, 16'h2000, 8'h00, 9'd0, 1'b0);
      send_word(ACT_READ, 16'h5000, 8'h00, 9'd0, 1'b0);
      send_word(ACT_READ, 16'h6000, 8'h00, 9'd0, 1'b0);
      send_word(ACT_WRITE, 16'h5180, 8'hFF, 9'd0, 1'b0);
      send_word(ACT_WRITE, 16'h5000, 8'h02, 9'd0, 1'b0);
      send_word(ACT_READ, 16'h5FFF, 8'h00, 9'd0, 1'b0);
      send_word(ACT_WRITE, 16'h8000, 8'h86, 9'd0, 1'b0);
      send_word(ACT_WRITE, 16'h8001, 8'hFF, 9'd0, 1'b0);
      send_word(ACT_WRITE, 16'h9FFE, 8'h55, 9'd0, 1'b0);
      send_word(ACT_WRITE, 16'h8003, {2'b00, EXT_OPEN_1}, 9'd0, 1'b0);
      send_word(ACT_PRG, 16'hC000, 8'h00, 9'd0, 1'b0);
      send_word(ACT_CHR, 16'h1FFF, 8'h00, 9'd0, 1'b0);
      send_word(ACT_WRITE, 16'hA000, 8'h01, 9'd0, 1'b0);
      send_word(ACT_WRITE, 16'hC001, 8'h01, 9'd0, 1'b0);
      send_word(ACT_WRITE, 16'hE001, 8'h00, 9'd0, 1'b0);
      send_word(ACT_TICK, 16'h0000, 8'h00, 9'd0, 1'b1);
      send_word(ACT_TICK, 16'hFFFF, 8'hFF, 9'd261, 1'b1);
      send_word(ACT_WRITE, 16'hE000, 8'h00, 9'd0, 1'b0);
      send_word(ACT_TICK, 16'h0000, 8'h00, 9'd239, 1'b0);
      send_word(ACT_WRITE, 16'h4FFF, 8'hFF, 9'd0, 1'b0);
      send_word(ACT_WRITE, 16'hA001, 8'hFF, 9'd0, 1'b0);
      send_word(ACT_SPARE_HI, 16'hFFFF, 8'hFF, 9'd261, 1'b1);
      send_word(ACT_CHR, 16'hFFFF, 8'h00, 9'd0, 1'b0);

      for (int p = 0; p < 6; p++) begin
         wait_drained();
         if (p != 0) begin
            csr_write(REG_PRG_BANK_COUNT,
                      p == 4 ? 32'($urandom_range(64, 2)) : 32'(cfg_count[p]));
            csr_write(REG_CHR_TWICE_PRG, {31'd0, cfg_double[p]});
         end
         send_idle_pct = idle_send[p];
         rsp_stall_pct = idle_recv[p];
         for (int n = 0; n < 140; n++) begin
            // block the receiver while words keep coming, so the input stalls
            if (p == 0 && n == 70) hold_req = 60;
            // pause the sender until everything is back
            if (p == 2 && n == 70) wait_drained();
            send_random_word();
         end
      end

      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("mmc3_clone_bank_mapper_with_protection verification clean");
      else
         $display("mmc3_clone_bank_mapper_with_protection verification failed");
      $finish;
   end

endmodule

@@ mmc3_clone_bank_mapper_with_protection.f @@
design/mmc3_pkg.sv
design/mmc3_clone_bank_mapper_with_protection.sv
design/mmc3_chk.sv
tb/mmc3_clone_bank_mapper_with_protection_tb.sv
